// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SDO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Checked on every clock edge, reset included.
`define SDO_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

// File: rtl/sdo_pkg.sv
// Types, constants and font table of the two-digit overlay.
package sdo_pkg;

  localparam int unsigned DefFrameWidth  = 1024;
  localparam int unsigned DefFrameHeight = 1024;

  localparam int unsigned CoordW  = 10;
  localparam int unsigned PixelW  = 8;
  localparam int unsigned OriginW = 11;
  localparam int unsigned MagW    = 5;
  localparam int unsigned GapW    = 6;
  localparam int unsigned ValueW  = 7;
  localparam int unsigned DiffW   = 13;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 8;

  localparam logic [MagW-1:0]   MagnifyRst   = 5'd1;
  localparam logic [GapW-1:0]   DigitGapRst  = 6'd5;
  localparam logic [PixelW-1:0] InkLevelRst  = 8'd180;
  localparam logic [ValueW-1:0] ValueMax     = 7'd99;

  typedef enum logic [2:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_MAGNIFY,
    REG_DIGIT_GAP,
    REG_SHOWN_VALUE,
    REG_CLEAR_ENABLE,
    REG_INK_LEVEL
  } sdo_reg_e;

  typedef struct packed {
    logic signed [OriginW-1:0] origin_x;
    logic signed [OriginW-1:0] origin_y;
    logic [MagW-1:0]           magnify;
    logic [GapW-1:0]           digit_gap;
    logic [ValueW-1:0]         shown_value;
    logic                      clear_enable;
    logic [PixelW-1:0]         ink_level;
  } sdo_cfg_t;

  // one word per digit, row 0 in the low bits, bit 2 of a row is the left column
  localparam logic [14:0] GLYPH [10] = '{
    {3'd7, 3'd5, 3'd5, 3'd5, 3'd7},
    {3'd7, 3'd2, 3'd2, 3'd6, 3'd2},
    {3'd7, 3'd4, 3'd7, 3'd1, 3'd7},
    {3'd7, 3'd1, 3'd7, 3'd1, 3'd7},
    {3'd1, 3'd1, 3'd7, 3'd5, 3'd5},
    {3'd7, 3'd1, 3'd7, 3'd4, 3'd7},
    {3'd7, 3'd5, 3'd7, 3'd4, 3'd7},
    {3'd1, 3'd1, 3'd1, 3'd1, 3'd7},
    {3'd7, 3'd5, 3'd7, 3'd5, 3'd7},
    {3'd7, 3'd1, 3'd7, 3'd5, 3'd7}
  };

  function automatic logic glyph_bit(logic [3:0] digit, logic [2:0] row, logic [1:0] col);
    logic [14:0] w;
    logic [2:0]  r;
    logic        b;
    w = (digit <= 4'd9) ? GLYPH[digit] : 15'd0;
    case (row)
      3'd0:    r = w[2:0];
      3'd1:    r = w[5:3];
      3'd2:    r = w[8:6];
      3'd3:    r = w[11:9];
      3'd4:    r = w[14:12];
      default: r = 3'd0;
    endcase
    case (col)
      2'd0:    b = r[2];
      2'd1:    b = r[1];
      2'd2:    b = r[0];
      default: b = 1'b0;
    endcase
    return b;
  endfunction

  // tens digit of a value up to 99 by reciprocal multiply
  function automatic logic [3:0] tens_of(logic [ValueW-1:0] v);
    logic [18:0] p;
    p = 19'(v) * 19'd205;
    return p[14:11];
  endfunction

endpackage

// File: rtl/sdo_regs.sv
// APB register file holding the overlay settings.
module sdo_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sdo_pkg::ApbAddrW-1:0]   paddr,
  input  logic [sdo_pkg::ApbDataW-1:0]   pwdata,
  output logic [sdo_pkg::ApbDataW-1:0]   prdata,
  output logic                           pready,
  output sdo_pkg::sdo_cfg_t              cfg_o
);
  import sdo_pkg::*;

  sdo_cfg_t cfg_q, cfg_d;
  sdo_reg_e idx;
  logic     wr_en;

  assign idx    = sdo_reg_e'(paddr[4:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_ORIGIN_X:     cfg_d.origin_x     = $signed(pwdata[OriginW-1:0]);
        REG_ORIGIN_Y:     cfg_d.origin_y     = $signed(pwdata[OriginW-1:0]);
        REG_MAGNIFY:      cfg_d.magnify      = pwdata[MagW-1:0];
        REG_DIGIT_GAP:    cfg_d.digit_gap    = pwdata[GapW-1:0];
        REG_SHOWN_VALUE:  cfg_d.shown_value  = (pwdata[ValueW-1:0] > ValueMax) ?
                                               ValueMax : pwdata[ValueW-1:0];
        REG_CLEAR_ENABLE: cfg_d.clear_enable = pwdata[0];
        REG_INK_LEVEL:    cfg_d.ink_level    = pwdata[PixelW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x     <= '0;
      cfg_q.origin_y     <= '0;
      cfg_q.magnify      <= MagnifyRst;
      cfg_q.digit_gap    <= DigitGapRst;
      cfg_q.shown_value  <= '0;
      cfg_q.clear_enable <= 1'b1;
      cfg_q.ink_level    <= InkLevelRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      REG_ORIGIN_X:     prdata = ApbDataW'($unsigned(cfg_q.origin_x));
      REG_ORIGIN_Y:     prdata = ApbDataW'($unsigned(cfg_q.origin_y));
      REG_MAGNIFY:      prdata = ApbDataW'(cfg_q.magnify);
      REG_DIGIT_GAP:    prdata = ApbDataW'(cfg_q.digit_gap);
      REG_SHOWN_VALUE:  prdata = ApbDataW'(cfg_q.shown_value);
      REG_CLEAR_ENABLE: prdata = ApbDataW'(cfg_q.clear_enable);
      REG_INK_LEVEL:    prdata = ApbDataW'(cfg_q.ink_level);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/sdo_pixel.sv
// Per-pixel box clear and glyph hit logic.
module sdo_pixel #(
  parameter int unsigned IMG_COLS = sdo_pkg::DefFrameWidth,
  parameter int unsigned IMG_ROWS = sdo_pkg::DefFrameHeight
) (
  input  sdo_pkg::sdo_cfg_t             cfg_i,
  input  logic [sdo_pkg::CoordW-1:0]    pixel_x_i,
  input  logic [sdo_pkg::CoordW-1:0]    pixel_y_i,
  input  logic [sdo_pkg::PixelW-1:0]    pixel_in_i,
  output logic [sdo_pkg::PixelW-1:0]    pixel_out_o
);
  import sdo_pkg::*;

  localparam logic [DiffW-1:0] FrameW = DiffW'(IMG_COLS);
  localparam logic [DiffW-1:0] FrameH = DiffW'(IMG_ROWS);

  logic signed [DiffW-1:0] dx, dy, m1, m2, m3, m4, m5, box_w, uoff, coff;
  logic signed [DiffW-1:0] off_a;
  logic [3:0] tens, units, digit_a;
  logic [2:0] row;
  logic       in_frame, row_ok, in_box, two_dig, lit_a, lit_b;

  function automatic logic digit_hit(logic [3:0] d, logic signed [DiffW-1:0] ddx,
                                     logic [2:0] r, logic rok,
                                     logic signed [DiffW-1:0] c1,
                                     logic signed [DiffW-1:0] c2,
                                     logic signed [DiffW-1:0] c3);
    logic [1:0] col;
    col = (ddx >= c2) ? 2'd2 : ((ddx >= c1) ? 2'd1 : 2'd0);
    return rok && (ddx >= 0) && (ddx < c3) && glyph_bit(d, r, col);
  endfunction

  assign dx = $signed({3'b000, pixel_x_i}) - DiffW'(cfg_i.origin_x);
  assign dy = $signed({3'b000, pixel_y_i}) - DiffW'(cfg_i.origin_y);

  assign m1    = $signed(DiffW'(cfg_i.magnify));
  assign m2    = m1 <<< 1;
  assign m3    = m1 + m2;
  assign m4    = m1 <<< 2;
  assign m5    = m4 + m1;
  assign box_w = (m3 <<< 1) + $signed(DiffW'(cfg_i.digit_gap));
  assign uoff  = m3 + $signed(DiffW'(cfg_i.digit_gap));
  assign coff  = uoff >>> 1;

  assign in_frame = ({3'b000, pixel_x_i} < FrameW) && ({3'b000, pixel_y_i} < FrameH)
                    && (cfg_i.magnify != '0);
  assign row_ok   = (dy >= 0) && (dy < m5);
  assign row      = (dy >= m4) ? 3'd4 : (dy >= m3) ? 3'd3 : (dy >= m2) ? 3'd2 :
                    (dy >= m1) ? 3'd1 : 3'd0;
  assign in_box   = (dx >= 0) && (dx < box_w) && row_ok;

  assign tens    = tens_of(cfg_i.shown_value);
  assign units   = 4'(cfg_i.shown_value - ValueW'(tens) * ValueW'(10));
  assign two_dig = cfg_i.shown_value >= ValueW'(10);
  assign digit_a = two_dig ? tens : cfg_i.shown_value[3:0];
  assign off_a   = two_dig ? '0 : coff;

  assign lit_a = digit_hit(digit_a, dx - off_a, row, row_ok, m1, m2, m3);
  assign lit_b = two_dig && digit_hit(units, dx - uoff, row, row_ok, m1, m2, m3);

  always_comb begin
    pixel_out_o = pixel_in_i;
    if (in_frame) begin
      if (cfg_i.clear_enable && in_box) pixel_out_o = '0;
      if (lit_a || lit_b) pixel_out_o = cfg_i.ink_level;
    end
  end

endmodule

// File: rtl/scaled_two_digit_overlay.sv
// Top level of the two-digit pixel stream overlay.
// Takes one pixel per clock and returns it in order: an input register feeds the
// overlay logic, whose value lands in the output register. Throughput is
// one pixel per cycle while the output side is ready; s_axis_tready_o drops only
// when both registers hold data and m_axis_tready_i is low. Settings are written
// over APB (byte address 4*index) and should change only between frames or while
// no pixel is in flight.
module scaled_two_digit_overlay #(
  parameter int unsigned IMG_COLS = sdo_pkg::DefFrameWidth,
  parameter int unsigned IMG_ROWS = sdo_pkg::DefFrameHeight
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [9:0] pixel_x, [19:10] pixel_y, [27:20] pixel_in, [31:28] zero
  input  logic [sdo_pkg::InTdataW-1:0]    s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [7:0] pixel_out
  output logic [sdo_pkg::OutTdataW-1:0]   m_axis_tdata_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sdo_pkg::ApbAddrW-1:0]    paddr,
  input  logic [sdo_pkg::ApbDataW-1:0]    pwdata,
  output logic [sdo_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);
  import sdo_pkg::*;

  sdo_cfg_t          cfg;
  logic              in_v_q, out_v_q, adv_out;
  logic [CoordW-1:0] px_q, py_q;
  logic [PixelW-1:0] pin_q, pix_res, pout_q;

  sdo_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sdo_pixel #(
    .IMG_COLS (IMG_COLS),
    .IMG_ROWS (IMG_ROWS)
  ) u_pixel (
    .cfg_i       (cfg),
    .pixel_x_i   (px_q),
    .pixel_y_i   (py_q),
    .pixel_in_i  (pin_q),
    .pixel_out_o (pix_res)
  );

  assign adv_out         = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_v_q || adv_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) in_v_q <= s_axis_tvalid_i;
      if (adv_out) out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      px_q  <= s_axis_tdata_i[9:0];
      py_q  <= s_axis_tdata_i[19:10];
      pin_q <= s_axis_tdata_i[27:20];
    end
    if (adv_out && in_v_q) pout_q <= pix_res;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = pout_q;

endmodule

// File: rtl/sdo_checker.sv
// Port-level checks of the overlay, bound to the top level.
`include "assert_macros.svh"

module sdo_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [sdo_pkg::OutTdataW-1:0]   m_axis_tdata_o,
  input logic                            psel,
  input logic                            pwrite,
  input logic [sdo_pkg::ApbAddrW-1:0]    paddr,
  input logic [sdo_pkg::ApbDataW-1:0]    prdata,
  input logic                            pready
);
  import sdo_pkg::*;

  // a stalled output transfer keeps its data
  `SDO_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))

  // an empty output register never blocks the input side
  `SDO_ASSERT_ALWAYS(a_rdy_when_empty, !m_axis_tvalid_o |-> s_axis_tready_o)

  // shown value reads back saturated
  `SDO_ASSERT(a_value_sat,
    psel && !pwrite && (paddr[4:2] == REG_SHOWN_VALUE) |-> prdata <= ApbDataW'(ValueMax))

  // the APB port never waits
  `SDO_ASSERT(a_pready_high, pready)

  // a pending input transfer with an empty output register is taken
  `SDO_ASSERT(a_in_take, s_axis_tvalid_i && !m_axis_tvalid_o |-> s_axis_tready_o)

endmodule

bind scaled_two_digit_overlay sdo_checker u_sdo_checker (.*);

// File: test/tb_scaled_two_digit_overlay.sv
// Self-checking testbench of the two-digit pixel stream overlay.
module tb_scaled_two_digit_overlay;
  import sdo_pkg::*;

  localparam int FRAME_W     = 1024;
  localparam int FRAME_H     = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int N_PRESET    = 8;
  localparam int N_PHASES    = 28;
  localparam int PRESET_ITEMS = 50;
  localparam int RANDOM_ITEMS = 62;
  localparam logic [ApbAddrW-1:0] ADDR_UNMAPPED = 5'd28;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [PixelW-1:0] pin;
    logic              pinned;
    logic [PixelW-1:0] pout;
  } pixel_case_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready_o;
  logic [InTdataW-1:0]   s_axis_tdata;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready;
  logic [OutTdataW-1:0]  m_axis_tdata_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ApbAddrW-1:0]   paddr;
  logic [ApbDataW-1:0]   pwdata;
  logic [ApbDataW-1:0]   prdata;
  logic                  pready;

  sdo_cfg_t              cfg;
  logic [PixelW-1:0]     pixel_q [$];
  logic                  pinned_valid;
  logic [PixelW-1:0]     pinned_pixel;
  bit                    quiet;
  bit                    hold_req;
  int                    err_cnt;
  int                    cycle_cnt;

  // reset settings: value 0 sits at columns 4..6, box is 11 x 5 at the origin
  pixel_case_t directed_pixels [14] = '{
    '{10'd0,    10'd0,    8'h5A, 1'b1, 8'd0},
    '{10'd4,    10'd0,    8'h11, 1'b1, 8'd180},
    '{10'd5,    10'd2,    8'hFF, 1'b1, 8'd0},
    '{10'd6,    10'd4,    8'h00, 1'b1, 8'd180},
    '{10'd4,    10'd1,    8'hC3, 1'b1, 8'd180},
    '{10'd10,   10'd4,    8'h77, 1'b1, 8'd0},
    '{10'd11,   10'd0,    8'hA5, 1'b1, 8'hA5},
    '{10'd0,    10'd5,    8'h3C, 1'b1, 8'h3C},
    '{10'd1023, 10'd1023, 8'hFF, 1'b1, 8'hFF},
    '{10'd1023, 10'd0,    8'h00, 1'b1, 8'h00},
    '{10'd0,    10'd1023, 8'h80, 1'b1, 8'h80},
    '{10'd341,  10'd682,  8'hAA, 1'b1, 8'hAA},
    '{10'd5,    10'd3,    8'h55, 1'b0, 8'h00},
    '{10'd3,    10'd4,    8'h01, 1'b0, 8'h00}
  };

  // origin_x, origin_y, magnify, digit_gap, shown_value, clear_enable, ink_level
  int preset_cfg [N_PRESET][7] = '{
    '{0,     0,     1,  5,  127, 1, 255},
    '{-5,    -3,    31, 63, 88,  0, 0},
    '{1000,  1010,  16, 0,  7,   1, 1},
    '{10,    20,    0,  5,  55,  1, 200},
    '{1023,  1023,  2,  0,  10,  1, 255},
    '{-1024, -1024, 4,  0,  42,  1, 9},
    '{-2,    -2,    3,  1,  9,   0, 128},
    '{300,   600,   5,  63, 100, 1, 77}
  };

  scaled_two_digit_overlay #(
    .IMG_COLS (FRAME_W),
    .IMG_ROWS (FRAME_H)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // 3x5 font, row 0 in the top bits, left column first
  function automatic logic [14:0] font_word(int digit);
    case (digit)
      0:       return 15'b111_101_101_101_111;
      1:       return 15'b010_110_010_010_111;
      2:       return 15'b111_001_111_100_111;
      3:       return 15'b111_001_111_001_111;
      4:       return 15'b101_101_111_001_001;
      5:       return 15'b111_100_111_001_111;
      6:       return 15'b111_100_111_101_111;
      7:       return 15'b111_001_001_001_001;
      8:       return 15'b111_101_111_101_111;
      9:       return 15'b111_101_111_001_111;
      default: return 15'b0;
    endcase
  endfunction

  function automatic logic cell_lit(int digit, int dx, int dy, int m);
    logic [14:0] w;
    if (dx < 0 || dy < 0 || dx >= 3 * m || dy >= 5 * m) return 1'b0;
    w = font_word(digit);
    return w[14 - 3 * (dy / m) - dx / m];
  endfunction

  function automatic logic [PixelW-1:0] overlay_pixel(sdo_cfg_t c, logic [CoordW-1:0] x,
                                                      logic [CoordW-1:0] y,
                                                      logic [PixelW-1:0] pin);
    int m, gap, v, dx, dy, dw, ox, oy;
    logic lit;
    logic [PixelW-1:0] res;
    res = pin;
    m   = c.magnify;
    gap = c.digit_gap;
    v   = c.shown_value;
    ox  = $signed(c.origin_x);
    oy  = $signed(c.origin_y);
    dx  = x;
    dy  = y;
    dx  = dx - ox;
    dy  = dy - oy;
    dw  = 3 * m;
    if (x < FRAME_W && y < FRAME_H && m >= 1) begin
      if (c.clear_enable && dx >= 0 && dx < 2 * dw + gap && dy >= 0 && dy < 5 * m)
        res = '0;
      if (v >= 10)
        lit = cell_lit(v / 10, dx, dy, m) || cell_lit(v % 10, dx - (dw + gap), dy, m);
      else
        lit = cell_lit(v, dx - (dw + gap) / 2, dy, m);
      if (lit) res = c.ink_level;
    end
    return res;
  endfunction

  function automatic logic [ApbDataW-1:0] cfg_field(sdo_reg_e r, output int width);
    case (r)
      REG_ORIGIN_X:     begin width = OriginW; return ApbDataW'(cfg.origin_x); end
      REG_ORIGIN_Y:     begin width = OriginW; return ApbDataW'(cfg.origin_y); end
      REG_MAGNIFY:      begin width = MagW;    return ApbDataW'(cfg.magnify); end
      REG_DIGIT_GAP:    begin width = GapW;    return ApbDataW'(cfg.digit_gap); end
      REG_SHOWN_VALUE:  begin width = ValueW;  return ApbDataW'(cfg.shown_value); end
      REG_CLEAR_ENABLE: begin width = 1;       return ApbDataW'(cfg.clear_enable); end
      default:          begin width = PixelW;  return ApbDataW'(cfg.ink_level); end
    endcase
  endfunction

  task automatic apb_xfer(input logic wr, input logic [ApbAddrW-1:0] addr,
                          input logic [ApbDataW-1:0] wdata, output logic [ApbDataW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(sdo_reg_e r, logic [ApbDataW-1:0] wdata);
    logic [ApbDataW-1:0] rdata;
    apb_xfer(1'b1, ApbAddrW'(4 * int'(r)), wdata, rdata);
    case (r)
      REG_ORIGIN_X:     cfg.origin_x     = wdata[OriginW-1:0];
      REG_ORIGIN_Y:     cfg.origin_y     = wdata[OriginW-1:0];
      REG_MAGNIFY:      cfg.magnify      = wdata[MagW-1:0];
      REG_DIGIT_GAP:    cfg.digit_gap    = wdata[GapW-1:0];
      REG_SHOWN_VALUE:  cfg.shown_value  = (wdata[ValueW-1:0] > ValueMax) ?
                                           ValueMax : wdata[ValueW-1:0];
      REG_CLEAR_ENABLE: cfg.clear_enable = wdata[0];
      REG_INK_LEVEL:    cfg.ink_level    = wdata[PixelW-1:0];
      default:          ;
    endcase
  endtask

  task automatic check_regs();
    logic [ApbDataW-1:0] rdata, field, mask;
    int width;
    sdo_reg_e reg_id;
    for (int i = 0; i <= int'(REG_INK_LEVEL); i++) begin
      reg_id = sdo_reg_e'(i);
      apb_xfer(1'b0, ApbAddrW'(4 * i), '0, rdata);
      field = cfg_field(reg_id, width);
      mask  = (ApbDataW'(1) << width) - 1;
      if (((rdata ^ field) & mask) != '0) begin
        $error("register %s: expected %0h, got %0h", reg_id.name(), field & mask,
               rdata & mask);
        err_cnt++;
      end
    end
  endtask

  task automatic send_pixel(logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                            logic [PixelW-1:0] pin, logic pinned, logic [PixelW-1:0] pout);
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, pin, y, x};
    pinned_valid  <= pinned;
    pinned_pixel  <= pout;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // mostly pixels around the indicator box, the rest anywhere in the frame
  task automatic send_random_pixel();
    int w, h, x, y;
    w = 6 * int'(cfg.magnify) + int'(cfg.digit_gap);
    h = 5 * int'(cfg.magnify);
    if ($urandom_range(0, 4) == 0) begin
      x = $urandom_range(0, FRAME_W - 1);
      y = $urandom_range(0, FRAME_H - 1);
    end else begin
      x = int'($signed(cfg.origin_x)) + int'($urandom_range(0, w + 7)) - 4;
      y = int'($signed(cfg.origin_y)) + int'($urandom_range(0, h + 7)) - 4;
      x = (x < 0) ? 0 : (x >= FRAME_W) ? FRAME_W - 1 : x;
      y = (y < 0) ? 0 : (y >= FRAME_H) ? FRAME_H - 1 : y;
    end
    send_pixel(CoordW'(x), CoordW'(y), PixelW'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  task automatic drain_stream();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : sink_ctrl
    int stall_cnt;
    stall_cnt     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_cnt = HOLD_CYCLES;
      end else if (stall_cnt == 0 && !quiet && $urandom_range(0, 9) == 0) begin
        stall_cnt = $urandom_range(1, 15);
      end
      if (stall_cnt > 0) begin
        m_axis_tready <= 1'b0;
        stall_cnt--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    logic [PixelW-1:0] want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready_o)
        pixel_q.push_back(pinned_valid ? pinned_pixel :
                          overlay_pixel(cfg, s_axis_tdata[9:0], s_axis_tdata[19:10],
                                        s_axis_tdata[27:20]));
      if (m_axis_tvalid_o && m_axis_tready) begin
        if (pixel_q.size() == 0) begin
          $error("pixel_out: unexpected transfer, got %0d", m_axis_tdata_o);
          err_cnt++;
        end else begin
          want = pixel_q.pop_front();
          if (m_axis_tdata_o !== want) begin
            $error("pixel_out: expected %0d, got %0d", want, m_axis_tdata_o);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    int vals [7];
    int items;
    logic [ApbDataW-1:0] rdata;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    pinned_valid  = 1'b0;
    pinned_pixel  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    err_cnt       = 0;
    cycle_cnt     = 0;
    cfg.origin_x     = '0;
    cfg.origin_y     = '0;
    cfg.magnify      = MagnifyRst;
    cfg.digit_gap    = DigitGapRst;
    cfg.shown_value  = '0;
    cfg.clear_enable = 1'b1;
    cfg.ink_level    = InkLevelRst;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    check_regs();
    apb_xfer(1'b1, ADDR_UNMAPPED, '1, rdata);
    check_regs();

    foreach (directed_pixels[i])
      send_pixel(directed_pixels[i].x, directed_pixels[i].y, directed_pixels[i].pin,
                 directed_pixels[i].pinned, directed_pixels[i].pout);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_stream();
      repeat (4) @(posedge clk_i);
      if (ph < N_PRESET) begin
        vals  = preset_cfg[ph];
        items = PRESET_ITEMS;
      end else begin
        vals[REG_ORIGIN_X] = ($urandom_range(0, 3) == 0) ?
                             int'($urandom_range(0, 2047)) - 1024 :
                             int'($urandom_range(0, 980)) - 20;
        vals[REG_ORIGIN_Y] = ($urandom_range(0, 3) == 0) ?
                             int'($urandom_range(0, 2047)) - 1024 :
                             int'($urandom_range(0, 980)) - 20;
        vals[REG_MAGNIFY]  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) :
                                                           $urandom_range(1, 6);
        vals[REG_DIGIT_GAP]    = $urandom_range(0, 63);
        vals[REG_SHOWN_VALUE]  = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 127) :
                                                               $urandom_range(0, 99);
        vals[REG_CLEAR_ENABLE] = $urandom_range(0, 1);
        vals[REG_INK_LEVEL]    = $urandom_range(0, 255);
        items = RANDOM_ITEMS;
      end
      for (int i = 0; i <= int'(REG_INK_LEVEL); i++)
        cfg_write(sdo_reg_e'(i), ApbDataW'(vals[i]));
      check_regs();
      quiet = (ph >= N_PHASES - 3);
      for (int k = 0; k < items; k++) begin
        // output side blocked while input keeps coming: pipeline fills
        if (ph == N_PRESET + 2 && k == 10) hold_req = 1'b1;
        // input paused until the pipeline is empty
        if (ph == N_PRESET + 4 && k == 30) drain_stream();
        send_random_pixel();
      end
    end

    drain_stream();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
